// ===== sv/skpr_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted key-pair registry: shared package
// Sizes, operation and status codes, beat structs and the cell control
// bundle used by the cell row, the resolver and the top level.
// ----------------------------------------------------------------------------
package skpr_pkg;

   // Table geometry
   localparam int DEPTH  = 64;
   localparam int IDX_W  = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);

   // Fixed field widths
   localparam int PAGE_W = 32;
   localparam int BUF_W  = 7;
   localparam int REF_W  = 16;
   localparam int POS_W  = 7;

   typedef enum logic [1:0] {
      OP_LOOKUP        = 2'd0,
      OP_INSERT        = 2'd1,
      OP_LOOKUP_INSERT = 2'd2,
      OP_SCAN          = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_FOUND      = 3'd0,
      ST_MISS       = 3'd1,
      ST_INSERTED   = 3'd2,
      ST_DUPLICATE  = 3'd3,
      ST_FULL       = 3'd4,
      ST_SCAN_ENTRY = 3'd5,
      ST_SCAN_EMPTY = 3'd6
   } status_type;

   typedef enum logic [2:0] {
      FSM_IDLE,
      FSM_COMPARE,
      FSM_RESOLVE,
      FSM_DECIDE,
      FSM_SCAN,
      FSM_SCAN_END
   } fsm_type;

   // Request beat
   typedef struct packed {
      op_type              operation;
      logic [PAGE_W-1:0]   page_number;
      logic [BUF_W-1:0]    buffer_index;
      logic [REF_W-1:0]    ref_value;
   } req_type;

   // Response beat
   typedef struct packed {
      status_type          status;
      logic [REF_W-1:0]    ref_out;
      logic [PAGE_W-1:0]   page_out;
      logic [POS_W-1:0]    position;
      logic                last;
   } rsp_type;

   // One table entry held by a cell
   typedef struct packed {
      logic [PAGE_W-1:0]   page;
      logic [BUF_W-1:0]    buffer;
      logic [REF_W-1:0]    ref_val;
   } entry_type;

   // Search key broadcast to every cell
   typedef struct packed {
      logic [PAGE_W-1:0]   page;
      logic [BUF_W-1:0]    buffer;
   } key_type;

   // Per-cell control
   typedef struct packed {
      logic compare_en;
      logic load_en;
      logic shift_en;
      logic rotate_en;
   } cell_ctrl_type;

   // Per-cell compare result
   typedef struct packed {
      logic le;   // stored key <= search key
      logic eq;   // stored key == search key
   } cell_flag_type;

   // Search outcome
   typedef struct packed {
      logic             hit;
      logic [CNT_W-1:0] pos;
      logic [REF_W-1:0] ref_val;
   } resolve_type;

endpackage

// ===== sv/skpr_cell.sv =====
// ----------------------------------------------------------------------------
// Sorted key-pair registry: table cell
// Holds one entry, compares it against the broadcast key and takes a new
// entry from the request, its lower neighbor or its upper neighbor.
// ----------------------------------------------------------------------------
module skpr_cell (
   input  logic                    clock,
   input  skpr_pkg::cell_ctrl_type ctrl,
   input  skpr_pkg::key_type       key,
   input  skpr_pkg::entry_type     new_entry,
   input  skpr_pkg::entry_type     left_entry,
   input  skpr_pkg::entry_type     right_entry,
   output skpr_pkg::entry_type     entry,
   output skpr_pkg::cell_flag_type flags
);
   import skpr_pkg::*;

   entry_type     entry_ff;
   entry_type     entry_in;
   cell_flag_type flags_ff;
   cell_flag_type flags_in;

   // Compare stored key with the search key
   always_comb begin
      flags_in.eq = (key.page == entry_ff.page) && (key.buffer == entry_ff.buffer);
      flags_in.le = (key.page > entry_ff.page) ||
                    ((key.page == entry_ff.page) && (key.buffer >= entry_ff.buffer));
   end

   // Select the next entry: load, shift up from below, or rotate down
   always_comb begin
      entry_in = entry_ff;
      if (ctrl.load_en) begin
         entry_in = new_entry;
      end else if (ctrl.shift_en) begin
         entry_in = left_entry;
      end else if (ctrl.rotate_en) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (ctrl.compare_en) begin
         flags_ff <= flags_in;
      end
   end

   assign entry = entry_ff;
   assign flags = flags_ff;

endmodule

// ===== sv/skpr_resolve.sv =====
// ----------------------------------------------------------------------------
// Sorted key-pair registry: search resolver
// Turns the registered per-cell compare flags into the upper-bound
// position, the hit flag and the reference of the matching entry.
// ----------------------------------------------------------------------------
module skpr_resolve (
   input  skpr_pkg::cell_flag_type           flags [skpr_pkg::DEPTH],
   input  skpr_pkg::entry_type               entries [skpr_pkg::DEPTH],
   input  logic [skpr_pkg::CNT_W-1:0]        count,
   output skpr_pkg::resolve_type             result
);
   import skpr_pkg::*;

   logic [DEPTH-1:0] lev;
   logic [DEPTH-1:0] eqv;
   logic [DEPTH:0]   bnd;
   logic [CNT_W-1:0] ub;
   logic [REF_W-1:0] hit_ref;

   // Mask flags to the filled part; lev is a prefix because the table is sorted
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         lev[i] = flags[i].le && (CNT_W'(i) < count);
         eqv[i] = flags[i].eq && (CNT_W'(i) < count);
      end
   end

   // Mark the first cell that is unfilled or whose key is above the search key
   always_comb begin
      bnd[0]     = !lev[0];
      for (int i = 1; i < DEPTH; i++) begin
         bnd[i] = lev[i-1] && !lev[i];
      end
      bnd[DEPTH] = lev[DEPTH-1];
   end

   // Encode the boundary and pick the matching reference
   always_comb begin
      ub      = '0;
      hit_ref = '0;
      for (int i = 0; i <= DEPTH; i++) begin
         if (bnd[i]) begin
            ub = ub | CNT_W'(i);
         end
      end
      for (int i = 0; i < DEPTH; i++) begin
         if (eqv[i]) begin
            hit_ref = hit_ref | entries[i].ref_val;
         end
      end
   end

   assign result.hit     = |eqv;
   assign result.pos     = (|eqv) ? (ub - CNT_W'(1)) : ub;
   assign result.ref_val = hit_ref;

endmodule

// ===== sv/sorted_key_pair_registry_core.sv =====
// ----------------------------------------------------------------------------
// Sorted key-pair registry core
// Sorted table of (page, buffer) keys held in a row of cells, with lookup,
// insert, lookup-or-insert and per-buffer scan.
// ----------------------------------------------------------------------------
// A request beat is taken when start is high and busy is low. Lookup, insert
// and lookup-or-insert pass through the compare, resolve and decide states
// before the next accept: in compare every cell compares its key, resolve
// takes the position from the cell flags, and decide forms the response and
// shifts the cells for an insert; the response strobes once, with last set.
// A scan runs one full rotation of the cell row past the head cell, then a
// scan-end state; it strobes once per matching entry in table order, or once
// with scan-empty status, at most one beat per cycle. The receiver cannot
// stall: rsp_strobe marks each response beat for exactly one cycle.
// ----------------------------------------------------------------------------
module sorted_key_pair_registry_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  skpr_pkg::req_type req_data,
   output logic              rsp_strobe,
   output skpr_pkg::rsp_type rsp_data
);
   import skpr_pkg::*;

   fsm_type           state_ff, state_in;
   req_type           req_ff, req_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   resolve_type       res_ff, res_in;
   logic [IDX_W-1:0]  scan_idx_ff, scan_idx_in;
   logic              pend_valid_ff, pend_valid_in;
   entry_type         pend_ff, pend_in;
   logic [IDX_W-1:0]  pend_pos_ff, pend_pos_in;
   logic              rsp_strobe_ff, rsp_strobe_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   cell_ctrl_type     cell_ctrl  [DEPTH];
   entry_type         cell_entry [DEPTH];
   cell_flag_type     cell_flag  [DEPTH];
   resolve_type       res_comb;
   key_type           key;
   entry_type         new_entry;
   logic              head_match;

   assign key.page          = req_ff.page_number;
   assign key.buffer        = req_ff.buffer_index;
   assign new_entry.page    = req_ff.page_number;
   assign new_entry.buffer  = req_ff.buffer_index;
   assign new_entry.ref_val = req_ff.ref_value;

   // Cell row: each cell sees its lower and upper neighbor
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      skpr_cell u_cell (
         .clock       (clock),
         .ctrl        (cell_ctrl[g]),
         .key         (key),
         .new_entry   (new_entry),
         .left_entry  (cell_entry[(g == 0) ? 0 : g - 1]),
         .right_entry (cell_entry[(g + 1) % DEPTH]),
         .entry       (cell_entry[g]),
         .flags       (cell_flag[g])
      );
   end

   skpr_resolve u_resolve (
      .flags   (cell_flag),
      .entries (cell_entry),
      .count   (count_ff),
      .result  (res_comb)
   );

   // Head cell holds entry scan_idx during a scan
   assign head_match = (CNT_W'(scan_idx_ff) < count_ff) &&
                       (cell_entry[0].buffer == req_ff.buffer_index);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FSM_IDLE: begin
            if (start) begin
               state_in = (req_data.operation == OP_SCAN) ? FSM_SCAN : FSM_COMPARE;
            end
         end
         FSM_COMPARE:  state_in = FSM_RESOLVE;
         FSM_RESOLVE:  state_in = FSM_DECIDE;
         FSM_DECIDE:   state_in = FSM_IDLE;
         FSM_SCAN: begin
            if (scan_idx_ff == IDX_W'(DEPTH - 1)) begin
               state_in = FSM_SCAN_END;
            end
         end
         FSM_SCAN_END: state_in = FSM_IDLE;
         default:      state_in = FSM_IDLE;
      endcase
   end

   // Datapath and cell control
   always_comb begin
      req_in        = req_ff;
      count_in      = count_ff;
      res_in        = res_ff;
      scan_idx_in   = scan_idx_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      pend_pos_in   = pend_pos_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = rsp_data_ff;
      for (int i = 0; i < DEPTH; i++) begin
         cell_ctrl[i] = '0;
      end

      case (state_ff)
         FSM_IDLE: begin
            // Capture the request beat
            if (start) begin
               req_in        = req_data;
               scan_idx_in   = '0;
               pend_valid_in = 1'b0;
            end
         end

         FSM_COMPARE: begin
            for (int i = 0; i < DEPTH; i++) begin
               cell_ctrl[i].compare_en = 1'b1;
            end
         end

         FSM_RESOLVE: begin
            res_in = res_comb;
         end

         FSM_DECIDE: begin
            rsp_strobe_in        = 1'b1;
            rsp_data_in.page_out = req_ff.page_number;
            rsp_data_in.position = POS_W'(res_ff.pos);
            rsp_data_in.last     = 1'b1;
            if (res_ff.hit) begin
               rsp_data_in.status  = (req_ff.operation == OP_INSERT) ? ST_DUPLICATE
                                                                      : ST_FOUND;
               rsp_data_in.ref_out = res_ff.ref_val;
            end else if (req_ff.operation == OP_LOOKUP) begin
               rsp_data_in.status  = ST_MISS;
               rsp_data_in.ref_out = '0;
            end else if (count_ff == CNT_W'(DEPTH)) begin
               rsp_data_in.status  = ST_FULL;
               rsp_data_in.ref_out = '0;
            end else begin
               // Insert: open a slot at pos and shift the later cells up
               rsp_data_in.status  = ST_INSERTED;
               rsp_data_in.ref_out = req_ff.ref_value;
               count_in            = count_ff + CNT_W'(1);
               for (int i = 0; i < DEPTH; i++) begin
                  cell_ctrl[i].load_en  = (CNT_W'(i) == res_ff.pos);
                  cell_ctrl[i].shift_en = (CNT_W'(i) > res_ff.pos);
               end
            end
         end

         FSM_SCAN: begin
            // Rotate the row; hold one match back so the final one gets last
            for (int i = 0; i < DEPTH; i++) begin
               cell_ctrl[i].rotate_en = 1'b1;
            end
            scan_idx_in = scan_idx_ff + IDX_W'(1);
            if (head_match) begin
               if (pend_valid_ff) begin
                  rsp_strobe_in        = 1'b1;
                  rsp_data_in.status   = ST_SCAN_ENTRY;
                  rsp_data_in.ref_out  = pend_ff.ref_val;
                  rsp_data_in.page_out = pend_ff.page;
                  rsp_data_in.position = POS_W'(pend_pos_ff);
                  rsp_data_in.last     = 1'b0;
               end
               pend_valid_in = 1'b1;
               pend_in       = cell_entry[0];
               pend_pos_in   = scan_idx_ff;
            end
         end

         FSM_SCAN_END: begin
            rsp_strobe_in    = 1'b1;
            rsp_data_in.last = 1'b1;
            if (pend_valid_ff) begin
               rsp_data_in.status   = ST_SCAN_ENTRY;
               rsp_data_in.ref_out  = pend_ff.ref_val;
               rsp_data_in.page_out = pend_ff.page;
               rsp_data_in.position = POS_W'(pend_pos_ff);
            end else begin
               rsp_data_in.status   = ST_SCAN_EMPTY;
               rsp_data_in.ref_out  = '0;
               rsp_data_in.page_out = req_ff.page_number;
               rsp_data_in.position = '0;
            end
            pend_valid_in = 1'b0;
         end

         default: begin
            rsp_strobe_in = 1'b0;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= FSM_IDLE;
         count_ff      <= '0;
         scan_idx_ff   <= '0;
         pend_valid_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         scan_idx_ff   <= scan_idx_in;
         pend_valid_ff <= pend_valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      res_ff      <= res_in;
      pend_ff     <= pend_in;
      pend_pos_ff <= pend_pos_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign busy       = (state_ff != FSM_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   // A response beat only follows a decide or scan cycle
   a_strobe_source: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> ($past(state_ff) == FSM_DECIDE || $past(state_ff) == FSM_SCAN ||
                         $past(state_ff) == FSM_SCAN_END))
      else $error("response beat without a decide or scan cycle");

   // Table never overfills
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count above depth");

   // Count only grows, by one, after a decide cycle
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && count_ff != $past(count_ff)) |->
         (count_ff == $past(count_ff) + CNT_W'(1) && $past(state_ff) == FSM_DECIDE))
      else $error("entry count changed outside an insert");

   // Every scan closes with a final beat
   a_scan_closes: assert property (@(posedge clock) disable iff (reset)
      (state_ff == FSM_SCAN_END) |=> (rsp_strobe_ff && rsp_data_ff.last))
      else $error("scan ended without a last beat");

   // An accepted request makes the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not start work");

endmodule

// ===== dv/sorted_key_pair_registry_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted key-pair registry core: testbench
// Drives lookup, insert, lookup-or-insert and scan commands through the
// start/busy handshake. A scoreboard keeps its own sorted copy of the table
// and checks every response beat in order. The run opens with a directed
// sequence on the edge keys, then runs random traffic under three sender
// idle patterns.
// ----------------------------------------------------------------------------
module sorted_key_pair_registry_core_test;
   import skpr_pkg::*;

   // -------------------------------------------------------------------------
   // Scoreboard: shadow table plus the queue of responses still to come
   // -------------------------------------------------------------------------
   class registry_scoreboard;
      logic [PAGE_W-1:0] held_page [DEPTH];
      logic [BUF_W-1:0]  held_buffer [DEPTH];
      logic [REF_W-1:0]  held_ref [DEPTH];
      int                held_count;
      int                peak_count;
      rsp_type           pending_beats[$];
      int                mismatches;
      int                beats_checked;

      function new();
         held_count    = 0;
         peak_count    = 0;
         mismatches    = 0;
         beats_checked = 0;
      endfunction

      function void report(string what, longint got, longint want);
         mismatches++;
         if (mismatches <= 40)
            $display("[%0t] ERROR %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
      endfunction

      // Queue one response beat
      function void push_beat(status_type st, logic [REF_W-1:0] rv, logic [PAGE_W-1:0] pg,
                              int pos, bit fin);
         rsp_type b;
         b.status   = st;
         b.ref_out  = rv;
         b.page_out = pg;
         b.position = POS_W'(pos);
         b.last     = fin;
         pending_beats.push_back(b);
      endfunction

      // Work out the responses to an accepted command and update the shadow table
      function void note_request(req_type rq);
         logic [PAGE_W+BUF_W-1:0] probe;
         int                      slot;
         int                      final_match;
         bit                      hit;

         probe = {rq.page_number, rq.buffer_index};

         if (rq.operation == OP_SCAN) begin
            final_match = -1;
            for (int i = 0; i < held_count; i++)
               if (held_buffer[i] == rq.buffer_index)
                  final_match = i;
            if (final_match < 0)
               push_beat(ST_SCAN_EMPTY, '0, rq.page_number, 0, 1'b1);
            else
               for (int i = 0; i < held_count; i++)
                  if (held_buffer[i] == rq.buffer_index)
                     push_beat(ST_SCAN_ENTRY, held_ref[i], held_page[i], i,
                               i == final_match);
            return;
         end

         // Insertion point: count of stored keys not above the probe
         slot = 0;
         while (slot < held_count && {held_page[slot], held_buffer[slot]} <= probe)
            slot++;
         hit = (slot > 0) && ({held_page[slot-1], held_buffer[slot-1]} == probe);

         if (hit) begin
            push_beat(rq.operation == OP_INSERT ? ST_DUPLICATE : ST_FOUND,
                      held_ref[slot-1], rq.page_number, slot - 1, 1'b1);
         end else if (rq.operation == OP_LOOKUP) begin
            push_beat(ST_MISS, '0, rq.page_number, slot, 1'b1);
         end else if (held_count >= DEPTH) begin
            push_beat(ST_FULL, '0, rq.page_number, slot, 1'b1);
         end else begin
            // Open a hole at the insertion point and place the new key
            for (int i = held_count; i > slot; i--) begin
               held_page[i]   = held_page[i-1];
               held_buffer[i] = held_buffer[i-1];
               held_ref[i]    = held_ref[i-1];
            end
            held_page[slot]   = rq.page_number;
            held_buffer[slot] = rq.buffer_index;
            held_ref[slot]    = rq.ref_value;
            held_count++;
            if (held_count > peak_count)
               peak_count = held_count;
            push_beat(ST_INSERTED, rq.ref_value, rq.page_number, slot, 1'b1);
         end
      endfunction

      // Compare one response beat against the oldest expectation
      function void check_response(rsp_type got);
         rsp_type want;
         if (pending_beats.size() == 0) begin
            report("response beat with nothing expected, status", got.status, 0);
            return;
         end
         want = pending_beats.pop_front();
         beats_checked++;
         if (got.status !== want.status)
            report("status", got.status, want.status);
         if (got.ref_out !== want.ref_out)
            report("ref_out", got.ref_out, want.ref_out);
         if (got.page_out !== want.page_out)
            report("page_out", got.page_out, want.page_out);
         if (got.position !== want.position)
            report("position", got.position, want.position);
         if (got.last !== want.last)
            report("last", got.last, want.last);
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Block under test
   // -------------------------------------------------------------------------
   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_strobe;
   rsp_type rsp_data;

   sorted_key_pair_registry_core uut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   registry_scoreboard sb = new();
   key_type            known_keys[$];
   int                 op_counts[4];

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Watchdog on the whole run
   initial begin
      #2000000;
      $display("sorted_key_pair_registry_core: mismatch");
      $finish;
   end

   // Check every response beat at the edge that ends its cycle
   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1)
         sb.check_response(rsp_data);
   end

   // Present one command, with a random idle gap first, and hold it until taken
   task automatic send_request(input req_type rq, input int idle_pct);
      int gap;
      gap = 0;
      while ($urandom_range(99) < idle_pct)
         gap++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= rq;
      do
         @(posedge clock);
      while (busy !== 1'b0);
      sb.note_request(rq);
      op_counts[rq.operation]++;
      if (rq.operation == OP_INSERT || rq.operation == OP_LOOKUP_INSERT)
         known_keys.push_back('{page: rq.page_number, buffer: rq.buffer_index});
   endtask

   task automatic send_fields(input op_type op, input logic [PAGE_W-1:0] pg,
                              input logic [BUF_W-1:0] bf, input logic [REF_W-1:0] rv);
      req_type rq;
      rq.operation    = op;
      rq.page_number  = pg;
      rq.buffer_index = bf;
      rq.ref_value    = rv;
      send_request(rq, 0);
   endtask

   // Random command: insert-heavy, keys clustered so that hits and runs occur
   function automatic req_type random_request();
      req_type rq;
      int      pick;
      key_type k;

      pick = $urandom_range(99);
      if (pick < 50)      rq.operation = OP_INSERT;
      else if (pick < 70) rq.operation = OP_LOOKUP_INSERT;
      else if (pick < 85) rq.operation = OP_LOOKUP;
      else                rq.operation = OP_SCAN;

      if (known_keys.size() > 0 && $urandom_range(99) < 25) begin
         k = known_keys[$urandom_range(known_keys.size() - 1)];
         rq.page_number  = k.page;
         rq.buffer_index = k.buffer;
      end else begin
         case ($urandom_range(3))
            0:       rq.page_number = $urandom_range(1) ? '1 : '0;
            1:       rq.page_number = $urandom_range(15);
            default: rq.page_number = $urandom;
         endcase
         rq.buffer_index = $urandom_range(1) ? BUF_W'($urandom_range(3))
                                             : BUF_W'($urandom_range(127));
      end
      rq.ref_value = REF_W'($urandom_range(65535));
      return rq;
   endfunction

   initial begin
      int phase_idle[3];
      int drain;

      phase_idle = '{29, 85, 0};
      reset      = 1'b1;
      start      = 1'b0;
      req_data   = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty table, edge keys, duplicates, hits, misses and scans
      send_fields(OP_LOOKUP,        32'h0000_0000, 7'h00, 16'h0000);
      send_fields(OP_SCAN,          32'h0000_0000, 7'h00, 16'h0000);
      send_fields(OP_LOOKUP_INSERT, 32'hFFFF_FFFF, 7'h7F, 16'hFFFF);
      send_fields(OP_INSERT,        32'h0000_0000, 7'h00, 16'h0000);
      send_fields(OP_INSERT,        32'h0000_0000, 7'h7F, 16'h1234);
      send_fields(OP_INSERT,        32'hFFFF_FFFF, 7'h00, 16'h5555);
      send_fields(OP_INSERT,        32'h8000_0000, 7'h40, 16'hAAAA);
      send_fields(OP_INSERT,        32'h0000_0000, 7'h7F, 16'h9999);
      send_fields(OP_LOOKUP,        32'hFFFF_FFFF, 7'h7F, 16'h0000);
      send_fields(OP_LOOKUP,        32'h0000_0000, 7'h01, 16'h0000);
      send_fields(OP_LOOKUP,        32'h7FFF_FFFF, 7'h40, 16'h0000);
      send_fields(OP_LOOKUP,        32'hFFFF_FFFF, 7'h7E, 16'h0000);
      send_fields(OP_LOOKUP_INSERT, 32'h0000_0000, 7'h00, 16'h7777);
      send_fields(OP_LOOKUP_INSERT, 32'h0000_0000, 7'h01, 16'h8001);
      send_fields(OP_INSERT,        32'h5555_5555, 7'h2A, 16'h00FF);
      send_fields(OP_SCAN,          32'h0000_0000, 7'h00, 16'h0000);
      send_fields(OP_SCAN,          32'h1234_5678, 7'h7F, 16'h0000);
      send_fields(OP_SCAN,          32'h0000_0000, 7'h01, 16'h0000);
      send_fields(OP_SCAN,          32'hDEAD_BEEF, 7'h55, 16'h0000);

      // Random traffic under three idle patterns
      for (int p = 0; p < 3; p++)
         for (int n = 0; n < 47; n++)
            send_request(random_request(), phase_idle[p]);
      start <= 1'b0;

      // Drain outstanding beats, then allow a full scan's worth of cycles
      drain = 0;
      while (sb.pending_beats.size() != 0 && drain < 2000) begin
         @(posedge clock);
         drain++;
      end
      repeat (DEPTH + 16) @(posedge clock);

      while (sb.pending_beats.size() != 0) begin
         sb.report("missing response beat, status", 0, sb.pending_beats[0].status);
         void'(sb.pending_beats.pop_front());
      end

      $display("Run covered %0d lookups, %0d inserts, %0d lookup-or-inserts, %0d scans;",
               op_counts[OP_LOOKUP], op_counts[OP_INSERT], op_counts[OP_LOOKUP_INSERT],
               op_counts[OP_SCAN]);
      $display("%0d response beats checked, table peaked at %0d of %0d entries, %0d errors.",
               sb.beats_checked, sb.peak_count, DEPTH, sb.mismatches);
      if (sb.mismatches == 0)
         $display("sorted_key_pair_registry_core: match");
      else
         $display("sorted_key_pair_registry_core: mismatch");
      $finish;
   end

endmodule

// ===== files.f =====
sv/skpr_pkg.sv
sv/skpr_cell.sv
sv/skpr_resolve.sv
sv/sorted_key_pair_registry_core.sv
dv/sorted_key_pair_registry_core_test.sv
